// ----- rtl/core/acsc_pkg.sv -----
// Alarm-clock setting controller: shared field widths, event codes and time constants.
// Used by alarm_clock_setting_controller_top. No dependencies.
package acsc_pkg;

  // Field widths
  localparam int unsigned ReqW    = 3;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned MsW     = 27;

  typedef logic [ReqW-1:0]    req_t;
  typedef logic [HourW-1:0]   hour_t;
  typedef logic [MinuteW-1:0] minute_t;
  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [MsW-1:0]     ms_t;

  // Event codes carried by req_type
  localparam req_t EvJoy   = 3'd0;
  localparam req_t EvRot   = 3'd1;
  localparam req_t EvCw    = 3'd2;
  localparam req_t EvCcw   = 3'd3;
  localparam req_t EvCheck = 3'd4;

  // Wrap limits, held one below the modulus
  localparam hour_t   HourMax   = 5'd23;
  localparam minute_t MinuteMax = 6'd59;

  // Milliseconds per hour and per minute
  localparam ms_t MsPerHour   = 27'd3600000;
  localparam ms_t MsPerMinute = 27'd60000;

endpackage

// ----- rtl/core/alarm_clock_setting_controller_top.sv -----
// Alarm-clock setting controller: mode state machine, settings and result register.
// Depends on acsc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per transaction:
//   req_type_i selects joystick press, rotary press, clockwise, counterclockwise
//   or alarm check; now_hour_i / now_minute_i give the running time for checks.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   event: the mode after the event, all four settings, the armed lamp, the
//   ringing flag and a time-load strobe with the time in milliseconds.
// Result: registered, and it appears in the cycle after the event is accepted.
// Throughput: one event per cycle unless a waiting result is stalled. The mode
//   and settings registers update in the accepting cycle, so the next event sees them at once.
// Stall: while a result waits and out_stall_i is high, in_stall_o is high; an
//   event is taken in the same cycle that the waiting result is taken.
// Reset: asynchronous, active low. Mode returns to init, all settings and
//   flags clear, and the output register empties.
module alarm_clock_setting_controller_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Event channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  acsc_pkg::req_t   req_type_i,
  input  acsc_pkg::hour_t  now_hour_i,
  input  acsc_pkg::minute_t now_minute_i,
  // Result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output acsc_pkg::mode_t  mode_o,
  output acsc_pkg::hour_t  clock_hour_setting_o,
  output acsc_pkg::minute_t clock_minute_setting_o,
  output acsc_pkg::hour_t  alarm_hour_setting_o,
  output acsc_pkg::minute_t alarm_minute_setting_o,
  output logic             armed_indicator_o,
  output logic             ringing_o,
  output logic             time_load_o,
  output acsc_pkg::ms_t    time_load_ms_o
);
  import acsc_pkg::*;

  typedef enum logic [ModeW-1:0] {
    M_INIT     = 4'd0,
    M_SETHOUR  = 4'd1,
    M_SETMIN   = 4'd2,
    M_RUN      = 4'd3,
    M_ARMED    = 4'd4,
    M_DISARMED = 4'd5,
    M_ALHOUR   = 4'd6,
    M_ALMIN    = 4'd7,
    M_RINGING  = 4'd8
  } mode_e;

  mode_e   mode_q, mode_d;
  hour_t   set_hour_q, set_hour_d;
  minute_t set_minute_q, set_minute_d;
  hour_t   alarm_hour_q, alarm_hour_d;
  minute_t alarm_minute_q, alarm_minute_d;
  logic    alarm_armed_q, alarm_armed_d;
  logic    checks_active_q, checks_active_d;
  logic    strobe_d;
  ms_t     ms_d;

  logic    out_valid_q;
  mode_t   out_mode_q;
  hour_t   out_set_hour_q, out_alarm_hour_q;
  minute_t out_set_minute_q, out_alarm_minute_q;
  logic    out_armed_q, out_ringing_q, out_strobe_q;
  ms_t     out_ms_q;

  logic    in_accept;
  logic    inc_ev;
  logic    alarm_due;

  // Handshake: take an event whenever the result register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign inc_ev    = (req_type_i == EvRot) || (req_type_i == EvCw);
  assign alarm_due = checks_active_q && alarm_armed_q &&
                     (now_hour_i == alarm_hour_q) && (now_minute_i == alarm_minute_q) &&
                     (alarm_minute_q != '0);

  // Next mode and settings for the event on the input
  always_comb begin
    mode_d          = mode_q;
    set_hour_d      = set_hour_q;
    set_minute_d    = set_minute_q;
    alarm_hour_d    = alarm_hour_q;
    alarm_minute_d  = alarm_minute_q;
    alarm_armed_d   = alarm_armed_q;
    checks_active_d = checks_active_q;
    strobe_d        = 1'b0;
    ms_d            = '0;

    case (mode_q)
      M_INIT: begin
        if (inc_ev) begin
          set_hour_d = (set_hour_q >= HourMax) ? '0 : set_hour_q + 1'b1;
          mode_d     = M_SETHOUR;
        end else if (req_type_i == EvJoy) begin
          mode_d = M_SETMIN;
        end
      end
      M_SETHOUR: begin
        if (inc_ev) begin
          set_hour_d = (set_hour_q >= HourMax) ? '0 : set_hour_q + 1'b1;
        end else if (req_type_i == EvCcw) begin
          set_hour_d = (set_hour_q != '0) ? set_hour_q - 1'b1 : '0;
        end else if (req_type_i == EvJoy) begin
          mode_d = M_SETMIN;
        end
      end
      M_SETMIN: begin
        if (inc_ev) begin
          set_minute_d = (set_minute_q >= MinuteMax) ? '0 : set_minute_q + 1'b1;
        end else if (req_type_i == EvCcw) begin
          set_minute_d = (set_minute_q != '0) ? set_minute_q - 1'b1 : '0;
        end else if (req_type_i == EvJoy) begin
          // Load time at full width; products stay below 2^27
          strobe_d = 1'b1;
          ms_d     = MsW'(MsW'(set_hour_q) * MsPerHour) +
                     MsW'(MsW'(set_minute_q) * MsPerMinute);
          mode_d   = M_RUN;
        end
      end
      M_RUN, M_ARMED: begin
        if (req_type_i == EvRot) begin
          if (mode_q == M_RUN) begin
            alarm_armed_d   = 1'b1;
            checks_active_d = 1'b1;
            mode_d          = M_ARMED;
          end else begin
            alarm_armed_d   = 1'b0;
            checks_active_d = 1'b0;
            mode_d          = M_DISARMED;
          end
        end else if (req_type_i == EvJoy) begin
          checks_active_d = 1'b0;
          alarm_hour_d    = '0;
          alarm_minute_d  = '0;
          mode_d          = M_ALHOUR;
        end else if (req_type_i == EvCheck && alarm_due) begin
          mode_d = M_RINGING;
        end
      end
      M_DISARMED: begin
        if (req_type_i == EvRot) begin
          alarm_armed_d   = 1'b1;
          checks_active_d = 1'b1;
          mode_d          = M_ARMED;
        end else if (req_type_i == EvJoy) begin
          checks_active_d = 1'b0;
          alarm_hour_d    = '0;
          alarm_minute_d  = '0;
          mode_d          = M_ALHOUR;
        end
      end
      M_ALHOUR: begin
        if (inc_ev) begin
          alarm_hour_d = (alarm_hour_q >= HourMax) ? '0 : alarm_hour_q + 1'b1;
        end else if (req_type_i == EvCcw) begin
          alarm_hour_d = (alarm_hour_q != '0) ? alarm_hour_q - 1'b1 : '0;
        end else if (req_type_i == EvJoy) begin
          mode_d = M_ALMIN;
        end
      end
      M_ALMIN: begin
        if (inc_ev) begin
          alarm_minute_d = (alarm_minute_q >= MinuteMax) ? '0 : alarm_minute_q + 1'b1;
        end else if (req_type_i == EvCcw) begin
          alarm_minute_d = (alarm_minute_q != '0) ? alarm_minute_q - 1'b1 : '0;
        end else if (req_type_i == EvJoy) begin
          mode_d = M_RUN;
        end
      end
      M_RINGING: begin
        if (req_type_i == EvJoy || req_type_i == EvRot) begin
          mode_d = M_RUN;
        end
      end
      default: begin
        mode_d = M_INIT;
      end
    endcase
  end

  // Mode, settings and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= M_INIT;
      set_hour_q      <= '0;
      set_minute_q    <= '0;
      alarm_hour_q    <= '0;
      alarm_minute_q  <= '0;
      alarm_armed_q   <= 1'b0;
      checks_active_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q          <= mode_d;
        set_hour_q      <= set_hour_d;
        set_minute_q    <= set_minute_d;
        alarm_hour_q    <= alarm_hour_d;
        alarm_minute_q  <= alarm_minute_d;
        alarm_armed_q   <= alarm_armed_d;
        checks_active_q <= checks_active_d;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_mode_q         <= mode_t'(mode_d);
      out_set_hour_q     <= set_hour_d;
      out_set_minute_q   <= set_minute_d;
      out_alarm_hour_q   <= alarm_hour_d;
      out_alarm_minute_q <= alarm_minute_d;
      out_armed_q        <= alarm_armed_d;
      out_ringing_q      <= (mode_d == M_RINGING);
      out_strobe_q       <= strobe_d;
      out_ms_q           <= ms_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign mode_o                 = out_mode_q;
  assign clock_hour_setting_o   = out_set_hour_q;
  assign clock_minute_setting_o = out_set_minute_q;
  assign alarm_hour_setting_o   = out_alarm_hour_q;
  assign alarm_minute_setting_o = out_alarm_minute_q;
  assign armed_indicator_o      = out_armed_q;
  assign ringing_o              = out_ringing_q;
  assign time_load_o            = out_strobe_q;
  assign time_load_ms_o         = out_ms_q;

  // Checks
  a_strobe_lands_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_load_o |-> mode_o == mode_t'(M_RUN))
    else $error("time-load strobe without run mode");

  a_ms_zero_without_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !time_load_o |-> time_load_ms_o == '0)
    else $error("time_load_ms nonzero without strobe");

  a_ringing_flag_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ringing_o == (mode_o == mode_t'(M_RINGING)))
    else $error("ringing flag disagrees with mode");

  a_ringing_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_RINGING |-> alarm_armed_q)
    else $error("ringing while alarm not armed");

  a_hold_when_result_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_q) && $stable(set_hour_q))
    else $error("state moved while result was stalled");

endmodule

// ----- tb/alarm_clock_setting_controller_top_tb.sv -----
// Self-checking testbench for the alarm-clock setting controller: clock and alarm editing,
// arming, alarm checks and ringing, predicted per transaction and compared on the result port.
// Depends on acsc_pkg and alarm_clock_setting_controller_top.
module alarm_clock_setting_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acsc_pkg::*;

  // Mode encoding as seen on mode_o
  localparam mode_t ModeInit        = 4'd0;
  localparam mode_t ModeSetHour     = 4'd1;
  localparam mode_t ModeSetMinute   = 4'd2;
  localparam mode_t ModeRun         = 4'd3;
  localparam mode_t ModeArmed       = 4'd4;
  localparam mode_t ModeDisarmed    = 4'd5;
  localparam mode_t ModeAlarmHour   = 4'd6;
  localparam mode_t ModeAlarmMinute = 4'd7;
  localparam mode_t ModeRinging     = 4'd8;

  // Event codes the block does not decode
  localparam req_t EvSpareFirst = 3'd5;
  localparam req_t EvSpareLast  = 3'd7;

  localparam int ResetCycles      = 11;
  localparam int WatchdogLimit    = 1000;
  localparam int EndSettleCycles  = 8;
  localparam int RandomPhaseItems = 180;
  localparam int MaxReported      = 10;

  typedef struct packed {
    mode_t   mode;
    hour_t   clock_hour;
    minute_t clock_minute;
    hour_t   alarm_hour;
    minute_t alarm_minute;
    logic    armed;
    logic    ringing;
    logic    time_load;
    ms_t     load_ms;
  } alarm_result_t;

  logic    clk_i;
  logic    rst_ni       = 1'b0;
  logic    in_valid_i   = 1'b0;
  logic    in_stall_o;
  req_t    req_type_i   = EvJoy;
  hour_t   now_hour_i   = '0;
  minute_t now_minute_i = '0;
  logic    out_valid_o;
  logic    out_stall_i  = 1'b0;
  mode_t   mode_o;
  hour_t   clock_hour_setting_o;
  minute_t clock_minute_setting_o;
  hour_t   alarm_hour_setting_o;
  minute_t alarm_minute_setting_o;
  logic    armed_indicator_o;
  logic    ringing_o;
  logic    time_load_o;
  ms_t     time_load_ms_o;

  // Predicted controller state
  mode_t   pred_mode         = ModeInit;
  hour_t   pred_set_hour     = '0;
  minute_t pred_set_minute   = '0;
  hour_t   pred_alarm_hour   = '0;
  minute_t pred_alarm_minute = '0;
  logic    pred_armed        = 1'b0;
  logic    pred_checks       = 1'b0;

  alarm_result_t expected_results[$];
  alarm_result_t observed;
  alarm_result_t wanted;
  int fail_count    = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  alarm_clock_setting_controller_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .req_type_i            (req_type_i),
    .now_hour_i            (now_hour_i),
    .now_minute_i          (now_minute_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .mode_o                (mode_o),
    .clock_hour_setting_o  (clock_hour_setting_o),
    .clock_minute_setting_o(clock_minute_setting_o),
    .alarm_hour_setting_o  (alarm_hour_setting_o),
    .alarm_minute_setting_o(alarm_minute_setting_o),
    .armed_indicator_o     (armed_indicator_o),
    .ringing_o             (ringing_o),
    .time_load_o           (time_load_o),
    .time_load_ms_o        (time_load_ms_o)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic hour_t hour_up(input hour_t h);
    return (h >= HourMax) ? '0 : h + 1'b1;
  endfunction

  function automatic minute_t minute_up(input minute_t m);
    return (m >= MinuteMax) ? '0 : m + 1'b1;
  endfunction

  // Advance the predicted state by one event and return the result it produces
  function automatic alarm_result_t predict_alarm_step(input req_t ev, input hour_t nh,
                                                       input minute_t nm);
    alarm_result_t r;
    logic          inc;
    logic          due;
    r   = '0;
    inc = (ev == EvRot) || (ev == EvCw);
    due = pred_checks && pred_armed && (nh == pred_alarm_hour) &&
          (nm == pred_alarm_minute) && (pred_alarm_minute != '0);
    case (pred_mode)
      ModeInit: begin
        if (inc) begin
          pred_set_hour = hour_up(pred_set_hour);
          pred_mode     = ModeSetHour;
        end else if (ev == EvJoy) begin
          pred_mode = ModeSetMinute;
        end
      end
      ModeSetHour: begin
        if (inc) pred_set_hour = hour_up(pred_set_hour);
        else if (ev == EvCcw) pred_set_hour = (pred_set_hour == '0) ? '0 : pred_set_hour - 1'b1;
        else if (ev == EvJoy) pred_mode = ModeSetMinute;
      end
      ModeSetMinute: begin
        if (inc) begin
          pred_set_minute = minute_up(pred_set_minute);
        end else if (ev == EvCcw) begin
          pred_set_minute = (pred_set_minute == '0) ? '0 : pred_set_minute - 1'b1;
        end else if (ev == EvJoy) begin
          // full-width product, no 16-bit truncation
          r.time_load = 1'b1;
          r.load_ms   = ms_t'(int'(pred_set_hour) * int'(MsPerHour) +
                              int'(pred_set_minute) * int'(MsPerMinute));
          pred_mode   = ModeRun;
        end
      end
      ModeRun, ModeArmed: begin
        if (ev == EvRot) begin
          pred_armed  = (pred_mode == ModeRun);
          pred_checks = (pred_mode == ModeRun);
          pred_mode   = (pred_mode == ModeRun) ? ModeArmed : ModeDisarmed;
        end else if (ev == EvJoy) begin
          pred_checks       = 1'b0;
          pred_alarm_hour   = '0;
          pred_alarm_minute = '0;
          pred_mode         = ModeAlarmHour;
        end else if (ev == EvCheck && due) begin
          pred_mode = ModeRinging;
        end
      end
      ModeDisarmed: begin
        if (ev == EvRot) begin
          pred_armed  = 1'b1;
          pred_checks = 1'b1;
          pred_mode   = ModeArmed;
        end else if (ev == EvJoy) begin
          pred_checks       = 1'b0;
          pred_alarm_hour   = '0;
          pred_alarm_minute = '0;
          pred_mode         = ModeAlarmHour;
        end
      end
      ModeAlarmHour: begin
        if (inc) begin
          pred_alarm_hour = hour_up(pred_alarm_hour);
        end else if (ev == EvCcw) begin
          pred_alarm_hour = (pred_alarm_hour == '0) ? '0 : pred_alarm_hour - 1'b1;
        end else if (ev == EvJoy) begin
          pred_mode = ModeAlarmMinute;
        end
      end
      ModeAlarmMinute: begin
        if (inc) begin
          pred_alarm_minute = minute_up(pred_alarm_minute);
        end else if (ev == EvCcw) begin
          pred_alarm_minute = (pred_alarm_minute == '0) ? '0 : pred_alarm_minute - 1'b1;
        end else if (ev == EvJoy) begin
          pred_mode = ModeRun;
        end
      end
      ModeRinging: begin
        if (ev == EvJoy || ev == EvRot) pred_mode = ModeRun;
      end
      default: pred_mode = ModeInit;
    endcase
    r.mode         = pred_mode;
    r.clock_hour   = pred_set_hour;
    r.clock_minute = pred_set_minute;
    r.alarm_hour   = pred_alarm_hour;
    r.alarm_minute = pred_alarm_minute;
    r.armed        = pred_armed;
    r.ringing      = (pred_mode == ModeRinging);
    return r;
  endfunction

  function automatic hour_t rand_hour();
    return hour_t'($urandom_range(31));
  endfunction

  function automatic minute_t rand_minute();
    return minute_t'($urandom_range(63));
  endfunction

  function automatic req_t pick_increment();
    return ($urandom_range(1) == 0) ? EvRot : EvCw;
  endfunction

  // Mostly short alarm edits, now and then a long one that wraps
  function automatic int pick_edit_count();
    return ($urandom_range(4) == 0) ? int'($urandom_range(90, 30)) : int'($urandom_range(8));
  endfunction

  // One event transaction: optional gap, hold until accepted, then predict
  task automatic send_event(input req_t ev, input hour_t nh, input minute_t nm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= ev;
    now_hour_i   <= nh;
    now_minute_i <= nm;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_alarm_step(ev, nh, nm));
  endtask

  // Button or rotary event; the time fields carry noise
  task automatic send_button(input req_t ev);
    send_event(ev, rand_hour(), rand_minute());
  endtask

  // Sender holds off until every pending result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Climb to the top value, wrap, saturate at zero, climb back to the top
  task automatic sweep_clock_field(input bit minute_sel);
    while (minute_sel ? (pred_set_minute != MinuteMax) : (pred_set_hour != HourMax))
      send_button(pick_increment());
    send_button(pick_increment());
    send_button(EvCcw);
    while (minute_sel ? (pred_set_minute != MinuteMax) : (pred_set_hour != HourMax))
      send_button(pick_increment());
  endtask

  // Clock setting is reachable only once after reset
  task automatic test_clock_setting();
    int exit_pick;
    exit_pick = $urandom_range(3);
    // events that init ignores
    send_button(EvCcw);
    send_event(EvCheck, rand_hour(), rand_minute());
    send_button(req_t'($urandom_range(EvSpareLast, EvSpareFirst)));
    if (exit_pick == 0) begin
      // straight to minute set, hour stays at zero
      send_button(EvJoy);
    end else begin
      send_button((exit_pick == 1) ? EvCw : EvRot);
      send_button(EvCcw);
      send_button(EvCcw);
      send_event(EvCheck, rand_hour(), rand_minute());
      send_button(req_t'($urandom_range(EvSpareLast, EvSpareFirst)));
      repeat (40) send_button(($urandom_range(3) == 0) ? EvCcw : pick_increment());
      sweep_clock_field(1'b0);
      send_button(EvJoy);
    end
    send_button(EvCcw);
    send_event(EvCheck, rand_hour(), rand_minute());
    repeat (40) send_button(($urandom_range(3) == 0) ? EvCcw : pick_increment());
    sweep_clock_field(1'b1);
    // leaving minute set strobes the time load
    send_button(EvJoy);
  endtask

  // Alarm editing, arming, matching and non-matching checks, ringing
  task automatic test_alarm_arming();
    send_button(EvJoy);
    send_button(EvCcw);
    send_button(EvCw);
    send_button(EvJoy);
    send_button(EvRot);
    send_button(EvJoy);
    // not yet armed: no ring
    send_event(EvCheck, 5'd1, 6'd1);
    send_button(EvRot);
    send_event(EvCheck, 5'd31, 6'd1);
    send_event(EvCheck, 5'd1, 6'd1);
    // ringing ignores turns and checks
    send_button(EvCcw);
    send_event(EvCheck, 5'd1, 6'd1);
    send_button(EvJoy);
    // checks stay active after ringing
    send_event(EvCheck, 5'd1, 6'd1);
    send_button(EvRot);
    send_button(EvRot);
    send_button(EvRot);
    send_event(EvCheck, 5'd1, 6'd1);
    send_button(EvCw);
    send_button(EvRot);
    // alarm hour keeps the armed flag but stops checks
    send_button(EvJoy);
    send_button(EvJoy);
    send_button(EvJoy);
    send_event(EvCheck, 5'd0, 6'd0);
    send_button(EvRot);
    // zero alarm minute never rings
    send_event(EvCheck, 5'd0, 6'd0);
    send_button(EvRot);
    send_button(EvJoy);
    send_button(EvJoy);
    send_button(EvJoy);
  endtask

  // Mostly well-formed use steered by the predicted mode, with some noise
  task automatic test_random_operation(input int n);
    req_t    ev;
    hour_t   nh;
    minute_t nm;
    int      r;
    int      edits_left;
    edits_left = pick_edit_count();
    repeat (n) begin
      r  = $urandom_range(99);
      nh = rand_hour();
      nm = rand_minute();
      ev = req_t'($urandom_range(EvSpareLast));
      case (pred_mode)
        ModeAlarmHour, ModeAlarmMinute: begin
          if (r < 90) begin
            if (edits_left > 0) begin
              ev = ($urandom_range(9) == 0) ? EvCcw : pick_increment();
              edits_left--;
            end else begin
              ev         = EvJoy;
              edits_left = pick_edit_count();
            end
          end
        end
        ModeRun: begin
          if (r < 40) ev = EvRot;
          else if (r < 60) ev = EvJoy;
          else if (r < 90) ev = EvCheck;
        end
        ModeArmed: begin
          if (r < 55) ev = EvCheck;
          else if (r < 70) ev = EvRot;
          else if (r < 80) ev = EvJoy;
        end
        ModeDisarmed: begin
          if (r < 45) ev = EvRot;
          else if (r < 70) ev = EvJoy;
        end
        ModeRinging: begin
          if (r < 50) ev = ($urandom_range(1) == 0) ? EvJoy : EvRot;
        end
        default: ;
      endcase
      // checks mostly hit the alarm time
      if (ev == EvCheck) begin
        case ($urandom_range(3))
          0, 1: begin
            nh = pred_alarm_hour;
            nm = pred_alarm_minute;
          end
          2: nh = pred_alarm_hour;
          default: ;
        endcase
      end
      send_event(ev, nh, nm);
    end
  endtask

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed = {mode_o, clock_hour_setting_o, clock_minute_setting_o, alarm_hour_setting_o,
                  alarm_minute_setting_o, armed_indicator_o, ringing_o, time_load_o,
                  time_load_ms_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported)
          $display("unexpected result transaction: mode=%0d, nothing pending", observed.mode);
      end else begin
        wanted = expected_results.pop_front();
        if (observed !== wanted) begin
          fail_count++;
          if (fail_count <= MaxReported) begin
            $display("mismatch exp: mode=%0d clk=%0d:%0d alm=%0d:%0d arm=%0b ring=%0b load=%0b ms=%0d",
                     wanted.mode, wanted.clock_hour, wanted.clock_minute, wanted.alarm_hour,
                     wanted.alarm_minute, wanted.armed, wanted.ringing, wanted.time_load,
                     wanted.load_ms);
            $display("         got: mode=%0d clk=%0d:%0d alm=%0d:%0d arm=%0b ring=%0b load=%0b ms=%0d",
                     observed.mode, observed.clock_hour, observed.clock_minute,
                     observed.alarm_hour, observed.alarm_minute, observed.armed,
                     observed.ringing, observed.time_load, observed.load_ms);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL alarm_clock_setting_controller_top");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 55;
    test_clock_setting();
    test_alarm_arming();
    test_random_operation(RandomPhaseItems);
    drain_results();

    send_idle_pct = 55;
    recv_idle_pct = 10;
    test_random_operation(RandomPhaseItems);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_operation(RandomPhaseItems);
    drain_results();

    repeat (EndSettleCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS alarm_clock_setting_controller_top");
    end else begin
      $display("FAIL alarm_clock_setting_controller_top");
    end
    $finish;
  end

endmodule
